// ===== design/irc_pkg.sv =====
`timescale 1ns / 1ps

package irc_pkg;

  localparam int IRC_ENTRIES    = 16;
  localparam int IRC_TIME_WIDTH = 32;
  localparam int ITEM_COUNT     = 1024;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INVAL  = 2'd1;
  localparam logic [1:0] REQ_FILL   = 2'd2;

  localparam logic [2:0] ST_MISS          = 3'd0;
  localparam logic [2:0] ST_FOUND_INVALID = 3'd1;
  localparam logic [2:0] ST_HIT           = 3'd2;
  localparam logic [2:0] ST_INVALIDATED   = 3'd3;
  localparam logic [2:0] ST_NO_EFFECT     = 3'd4;
  localparam logic [2:0] ST_REVALIDATED   = 3'd5;
  localparam logic [2:0] ST_PLACED        = 3'd6;
  localparam logic [2:0] ST_ALREADY_VALID = 3'd7;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INVAL,
    OP_FILL,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  item_id;
    logic [31:0] update_time;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic       replaced_occupied;
    logic [9:0] replaced_item_id;
  } rsp_t;

  typedef struct packed {
    op_t         op;
    logic [9:0]  item_id;
    logic [31:0] update_time;
    logic [31:0] now;
  } cmd_t;

endpackage

// ===== design/irc_front.sv =====
`timescale 1ns / 1ps

module irc_front import irc_pkg::*; (
  input  logic start,
  input  req_t req,
  input  logic q_full,
  output logic busy,
  output logic push,
  output cmd_t cmd
);

  localparam logic [16:0] ITEM_LIMIT = 17'(ITEM_COUNT);

  logic id_ok;
  op_t  op;

  assign id_ok = {7'b0, req.item_id} < ITEM_LIMIT;

  always_comb begin
    unique case (req.req_type)
      REQ_LOOKUP: op = OP_LOOKUP;
      REQ_INVAL:  op = OP_INVAL;
      REQ_FILL:   op = OP_FILL;
      default:    op = OP_NONE;
    endcase
    if (!id_ok) begin
      op = OP_NONE;
    end
  end

  assign busy             = q_full;
  assign push             = start && !q_full;
  assign cmd.op           = op;
  assign cmd.item_id      = req.item_id;
  assign cmd.update_time  = req.update_time;
  assign cmd.now          = req.now;

endmodule

// ===== design/irc_queue.sv =====
`timescale 1ns / 1ps

module irc_queue import irc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = count == '0;
  assign full  = count == DEPTH_CNT;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_cmd;
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");
`endif

endmodule

// ===== design/irc_back.sv =====
`timescale 1ns / 1ps

module irc_back import irc_pkg::*; #(
  parameter int ENTRIES    = IRC_ENTRIES,
  parameter int TIME_WIDTH = IRC_TIME_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t head,
  input  logic q_empty,
  output logic pop,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PLACE
  } state_t;

  state_t               state;
  logic [ENTRIES-1:0]   entry_occupied;
  logic [ENTRIES-1:0]   entry_valid;
  logic [9:0]           entry_item        [ENTRIES];
  logic [TIME_WIDTH-1:0] entry_update_time [ENTRIES];
  logic [TIME_WIDTH-1:0] entry_access_time [ENTRIES];

  cmd_t             cur;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             empty_found;
  logic [IDX_W-1:0] empty_idx;
  logic [IDX_W-1:0] scan_idx;
  logic             inv_found;
  logic [IDX_W-1:0] inv_idx;
  logic [TIME_WIDTH-1:0] inv_time;
  logic [IDX_W-1:0] all_idx;
  logic [TIME_WIDTH-1:0] all_time;

  logic [ENTRIES-1:0] match;
  logic [IDX_W-1:0]   match_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   victim;
  logic [TIME_WIDTH+31:0] upd_ext;
  logic [TIME_WIDTH+31:0] now_ext;
  logic [TIME_WIDTH-1:0]  cur_upd;
  logic [TIME_WIDTH-1:0]  cur_now;
  logic [TIME_WIDTH-1:0]  scan_time;
  logic [IDX_W+3:0] hit_ext;
  logic [IDX_W+3:0] empty_ext;
  logic [IDX_W+3:0] victim_ext;

  // tag compare and priority encode, lowest index wins
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = entry_occupied[i] && (entry_item[i] == head.item_id);
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!entry_occupied[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign upd_ext    = {{TIME_WIDTH{1'b0}}, cur.update_time};
  assign now_ext    = {{TIME_WIDTH{1'b0}}, cur.now};
  assign cur_upd    = upd_ext[TIME_WIDTH-1:0];
  assign cur_now    = now_ext[TIME_WIDTH-1:0];
  assign scan_time  = entry_access_time[scan_idx];
  assign victim     = inv_found ? inv_idx : all_idx;
  assign hit_ext    = {4'b0, hit_idx};
  assign empty_ext  = {4'b0, empty_idx};
  assign victim_ext = {4'b0, victim};
  assign pop        = (state == S_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      entry_occupied <= '0;
      entry_valid    <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur         <= head;
            hit         <= |match;
            hit_idx     <= match_idx;
            empty_found <= ~&entry_occupied;
            empty_idx   <= free_idx;
            state       <= S_EXEC;
          end
        end
        S_EXEC: begin
          state                 <= S_IDLE;
          done                  <= 1'b1;
          rsp.status            <= ST_NO_EFFECT;
          rsp.slot              <= '0;
          rsp.replaced_occupied <= 1'b0;
          rsp.replaced_item_id  <= '0;
          unique case (cur.op)
            OP_LOOKUP: begin
              if (!hit) begin
                rsp.status <= ST_MISS;
              end else if (!entry_valid[hit_idx]) begin
                rsp.status <= ST_FOUND_INVALID;
                rsp.slot   <= hit_ext[3:0];
              end else begin
                rsp.status <= ST_HIT;
                rsp.slot   <= hit_ext[3:0];
                entry_access_time[hit_idx] <= cur_now;
              end
            end
            OP_INVAL: begin
              if (hit && (cur_upd > entry_update_time[hit_idx])) begin
                entry_valid[hit_idx] <= 1'b0;
                rsp.status <= ST_INVALIDATED;
                rsp.slot   <= hit_ext[3:0];
              end
            end
            OP_FILL: begin
              if (hit) begin
                rsp.slot <= hit_ext[3:0];
                if (entry_valid[hit_idx]) begin
                  rsp.status <= ST_ALREADY_VALID;
                end else begin
                  entry_valid[hit_idx]       <= 1'b1;
                  entry_update_time[hit_idx] <= cur_now;
                  entry_access_time[hit_idx] <= cur_now;
                  rsp.status <= ST_REVALIDATED;
                end
              end else if (empty_found) begin
                entry_occupied[empty_idx]    <= 1'b1;
                entry_valid[empty_idx]       <= 1'b1;
                entry_item[empty_idx]        <= cur.item_id;
                entry_update_time[empty_idx] <= cur_now;
                entry_access_time[empty_idx] <= cur_now;
                rsp.status <= ST_PLACED;
                rsp.slot   <= empty_ext[3:0];
              end else begin
                done      <= 1'b0;
                scan_idx  <= '0;
                inv_found <= 1'b0;
                state     <= S_SCAN;
              end
            end
            OP_NONE: begin
            end
          endcase
        end
        S_SCAN: begin
          // oldest invalid entry and oldest entry overall
          if (!entry_valid[scan_idx] && (!inv_found || scan_time < inv_time)) begin
            inv_found <= 1'b1;
            inv_idx   <= scan_idx;
            inv_time  <= scan_time;
          end
          if (scan_idx == '0 || scan_time < all_time) begin
            all_idx  <= scan_idx;
            all_time <= scan_time;
          end
          if (scan_idx == LAST_IDX) begin
            state <= S_PLACE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_PLACE: begin
          entry_valid[victim]       <= 1'b1;
          entry_item[victim]        <= cur.item_id;
          entry_update_time[victim] <= cur_now;
          entry_access_time[victim] <= cur_now;
          rsp.status            <= ST_PLACED;
          rsp.slot              <= victim_ext[3:0];
          rsp.replaced_occupied <= 1'b1;
          rsp.replaced_item_id  <= entry_item[victim];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_valid_occupied: assert property (@(posedge clk) disable iff (rst)
      (entry_valid & ~entry_occupied) == '0)
    else $error("valid entry that is not occupied");
  a_scan_full: assert property (@(posedge clk) disable iff (rst)
      state == S_SCAN |-> &entry_occupied)
    else $error("victim scan with a free entry");
  a_done_source: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(state) == S_EXEC || $past(state) == S_PLACE)
    else $error("result outside execute or place");
  a_replace_placed: assert property (@(posedge clk) disable iff (rst)
      done && rsp.replaced_occupied |-> rsp.status == ST_PLACED)
    else $error("eviction reported without placement");
`endif

endmodule

// ===== design/invalidation_report_client_cache.sv =====
`timescale 1ns / 1ps

// channel  | ports               | transfer
// ---------+---------------------+------------------------------------
// request  | start, busy, req    | rising edge with start high, busy low
// result   | done, rsp           | one cycle with done high, no stall
//
// requests enter a two-deep queue; the back end handles each in turn
// (tag match, then execute) and pops the next one only after its result.
// a fill that misses a full cache adds an access-time scan over every
// entry that picks the victim, then a place step.
// synchronous reset empties the queue and marks every entry free.
// busy is high while the queue is full; results cannot be held off.

module invalidation_report_client_cache import irc_pkg::*; #(
  parameter int ENTRIES    = IRC_ENTRIES,
  parameter int TIME_WIDTH = IRC_TIME_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  irc_front u_front (
    .start  (start),
    .req    (req),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .cmd    (push_cmd)
  );

  irc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  irc_back #(
    .ENTRIES    (ENTRIES),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .done    (done),
    .rsp     (rsp)
  );

endmodule
